// ===== rtl/core/tsuwb_pkg.sv =====
// ----------------------------------------------------------------------------
// tsuwb_pkg
// Shared types and constants for the type set union window bitmap block.
// ----------------------------------------------------------------------------
`default_nettype none
package tsuwb_pkg;
  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned MAX_MERGED = 64;
  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned MW = $clog2(MAX_MERGED + 1);

  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  typedef struct packed {
    logic [CW-1:0] first_cnt;
    logic [CW-1:0] second_cnt;
    logic          ovf;
  } job_t;
endpackage
`default_nettype wire

// ===== rtl/core/tsuwb_if.sv =====
// ----------------------------------------------------------------------------
// tsuwb_in_if / tsuwb_out_if
// Valid/ready channels for input items and result blocks.
// ----------------------------------------------------------------------------
`default_nettype none
interface tsuwb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] type_code;
  modport source (output valid, kind, type_code, input ready);
  modport sink (input valid, kind, type_code, output ready);
endinterface

interface tsuwb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  window;
  logic [5:0]  bitmap_bytes;
  logic [63:0] bits_word0;
  logic [63:0] bits_word1;
  logic [63:0] bits_word2;
  logic [63:0] bits_word3;
  logic        empty_union;
  logic        truncated;
  logic        load_overflow;
  logic        last_block;
  modport source (output valid, window, bitmap_bytes, bits_word0, bits_word1,
                  bits_word2, bits_word3, empty_union, truncated, load_overflow,
                  last_block, input ready);
  modport sink (input valid, window, bitmap_bytes, bits_word0, bits_word1,
                bits_word2, bits_word3, empty_union, truncated, load_overflow,
                last_block, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tsuwb_ram.sv =====
// ----------------------------------------------------------------------------
// tsuwb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tsuwb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/tsuwb_front.sv =====
// ----------------------------------------------------------------------------
// tsuwb_front
// Accepts items, stores loads into the list RAMs and queues finish jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module tsuwb_front
  import tsuwb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  tsuwb_in_if.sink           in_ch,
  output logic               job_valid,
  input  wire logic          job_ready,
  output job_t               job,
  output logic               we_a,
  output logic               we_b,
  output logic [AW-1:0]      waddr,
  output logic [15:0]        wdata
);
  logic [CW-1:0] cnt_a_r, cnt_b_r;
  logic          ovf_r, job_valid_r;
  job_t          job_r;
  logic          acc, full_a, full_b;

  // A finish waits in job_r; loads are held off until the back end takes it,
  // since the lists are being read.
  assign in_ch.ready = !job_valid_r;
  assign acc    = in_ch.valid && in_ch.ready;
  assign full_a = (cnt_a_r == CW'(LIST_DEPTH));
  assign full_b = (cnt_b_r == CW'(LIST_DEPTH));
  assign we_a   = acc && in_ch.kind == KIND_FIRST && !full_a;
  assign we_b   = acc && in_ch.kind == KIND_SECOND && !full_b;
  assign waddr  = (in_ch.kind == KIND_FIRST) ? cnt_a_r[AW-1:0] : cnt_b_r[AW-1:0];
  assign wdata  = in_ch.type_code;
  assign job_valid = job_valid_r;
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      job_valid_r <= 1'b0;
    end else begin
      if (job_valid_r && job_ready) job_valid_r <= 1'b0;
      if (acc) begin
        unique case (in_ch.kind)
          KIND_FIRST: begin
            if (full_a) ovf_r <= 1'b1;
            else cnt_a_r <= cnt_a_r + 1'b1;
          end
          KIND_SECOND: begin
            if (full_b) ovf_r <= 1'b1;
            else cnt_b_r <= cnt_b_r + 1'b1;
          end
          KIND_FINISH: begin
            job_r       <= '{first_cnt: cnt_a_r, second_cnt: cnt_b_r, ovf: ovf_r};
            job_valid_r <= 1'b1;
            cnt_a_r     <= '0;
            cnt_b_r     <= '0;
            ovf_r       <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/tsuwb_back.sv =====
// ----------------------------------------------------------------------------
// tsuwb_back
// Merges the two lists and builds window blocks, one result per block.
// ----------------------------------------------------------------------------
`default_nettype none
module tsuwb_back
  import tsuwb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  job_t               job,
  output logic [AW-1:0]      raddr_a,
  output logic [AW-1:0]      raddr_b,
  input  wire logic [15:0]   rdata_a,
  input  wire logic [15:0]   rdata_b,
  tsuwb_out_if.source        out_ch
);
  typedef enum logic [1:0] {S_IDLE, S_READ, S_STEP, S_OUT} state_t;

  state_t        state_r;
  logic [CW-1:0] i_r, j_r, na_r, nb_r;
  logic [MW-1:0] n_r;
  logic          ovf_r, trunc_r, have_r, final_r, scan_r;
  logic [7:0]    win_r;
  logic [5:0]    len_r;
  logic [255:0]  bits_r;

  logic          a_left, b_left, take_a, take_b, done;
  logic [15:0]   val;
  logic [7:0]    voff;
  logic [5:0]    vlen;

  assign raddr_a = i_r[AW-1:0];
  assign raddr_b = j_r[AW-1:0];
  assign a_left  = i_r < na_r;
  assign b_left  = j_r < nb_r;
  assign done    = !(a_left || b_left) || n_r == MW'(MAX_MERGED);
  assign take_b  = !a_left || (b_left && rdata_a > rdata_b);
  assign take_a  = !take_b;
  assign val     = take_b ? rdata_b : rdata_a;
  assign voff    = val[7:0];
  assign vlen    = {1'b0, voff[7:3]} + 6'd1;
  // The lists stay in use until the last block transfers.
  assign job_ready = (state_r == S_OUT) && final_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            i_r     <= '0;
            j_r     <= '0;
            n_r     <= '0;
            na_r    <= job.first_cnt;
            nb_r    <= job.second_cnt;
            ovf_r   <= job.ovf;
            have_r  <= 1'b0;
            scan_r  <= 1'b1;
            bits_r  <= '0;
            len_r   <= '0;
            win_r   <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_STEP;
        S_STEP: begin
          if (scan_r) begin
            // Counting pass: finds whether the merge limit drops values.
            if (done) begin
              trunc_r <= (a_left || b_left);
              scan_r  <= 1'b0;
              i_r     <= '0;
              j_r     <= '0;
              n_r     <= '0;
            end else begin
              if (take_a) i_r <= i_r + 1'b1;
              if (take_b || (a_left && b_left && rdata_a == rdata_b)) j_r <= j_r + 1'b1;
              n_r <= n_r + 1'b1;
            end
            state_r <= S_READ;
          end else if (done) begin
            out_ch.window        <= have_r ? win_r : 8'd0;
            out_ch.bitmap_bytes  <= have_r ? len_r : 6'd0;
            {out_ch.bits_word0, out_ch.bits_word1, out_ch.bits_word2,
             out_ch.bits_word3} <= have_r ? bits_r : '0;
            out_ch.empty_union   <= !have_r;
            out_ch.truncated     <= trunc_r;
            out_ch.load_overflow <= ovf_r;
            out_ch.last_block    <= 1'b1;
            out_ch.valid         <= 1'b1;
            final_r              <= 1'b1;
            state_r              <= S_OUT;
          end else begin
            if (take_a) i_r <= i_r + 1'b1;
            if (take_b || (a_left && b_left && rdata_a == rdata_b)) j_r <= j_r + 1'b1;
            n_r    <= n_r + 1'b1;
            have_r <= 1'b1;
            if (have_r && val[15:8] != win_r) begin
              // Close current block, emit it, then restart with this value.
              out_ch.window        <= win_r;
              out_ch.bitmap_bytes  <= len_r;
              {out_ch.bits_word0, out_ch.bits_word1, out_ch.bits_word2,
               out_ch.bits_word3} <= bits_r;
              out_ch.empty_union   <= 1'b0;
              out_ch.truncated     <= trunc_r;
              out_ch.load_overflow <= ovf_r;
              out_ch.last_block    <= 1'b0;
              out_ch.valid         <= 1'b1;
              final_r              <= 1'b0;
              bits_r  <= 256'd1 << (8'd255 - voff);
              len_r   <= vlen;
              win_r   <= val[15:8];
              state_r <= S_OUT;
            end else begin
              bits_r  <= bits_r | (256'd1 << (8'd255 - voff));
              if (vlen > len_r) len_r <= vlen;
              win_r   <= val[15:8];
              state_r <= S_READ;
            end
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state_r      <= final_r ? S_IDLE : S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/type_set_union_window_bitmap.sv =====
// ----------------------------------------------------------------------------
// type_set_union_window_bitmap
// Sorted union of two type-code lists, emitted as windowed type bitmaps.
// ----------------------------------------------------------------------------
// Loads write a list RAM directly. A finish item is handed to the back end,
// which walks the two lists twice with a two-pointer merge: a counting pass
// that finds whether the merge limit drops values, then an encoding pass.
// Each merged value takes a RAM read, then a compare. Each block handed out
// waits while the receiver stalls. Input is held off from a finish until its
// last block has transferred.
`default_nettype none
module type_set_union_window_bitmap
  import tsuwb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  tsuwb_in_if.sink    in_ch,
  tsuwb_out_if.source out_ch
);
  logic          job_valid, job_ready, we_a, we_b;
  job_t          job;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [15:0]   wdata, rdata_a, rdata_b;

  tsuwb_front u_front (
    .clk, .rst_n, .in_ch, .job_valid, .job_ready, .job,
    .we_a, .we_b, .waddr, .wdata
  );

  tsuwb_ram #(.WIDTH(16), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk, .we(we_a), .waddr, .wdata, .raddr(raddr_a), .rdata(rdata_a)
  );

  tsuwb_ram #(.WIDTH(16), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk, .we(we_b), .waddr, .wdata, .raddr(raddr_b), .rdata(rdata_b)
  );

  tsuwb_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .raddr_a, .raddr_b, .rdata_a, .rdata_b, .out_ch
  );
endmodule
`default_nettype wire
